/* hdl/lkpc_pkg.sv */
package lkpc_pkg;

	localparam int ENTRIES = 64;
	localparam int KEY_BITS = 58;
	localparam int STAMP_W = 64;
	localparam int CTR_W = 32;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 7;
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int SLOT_W = 6;
	localparam int OCC_W = 7;
	localparam int STAT_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT      = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_EVICTED  = 3'd2,
		STAT_REFUSED  = 3'd3,
		STAT_AVAIL    = 3'd4,
		STAT_UNAVAIL  = 3'd5
	} status_t;

	typedef enum logic {
		FN_USE   = 1'b0,
		FN_QUERY = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 1'b0,
		CFG_EVICT    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic             clear;
		logic             step;
		logic [IDX_W-1:0] idx;
		logic             live;
	} scan_ctl_t;

	typedef struct packed {
		logic                hit;
		logic [IDX_W-1:0]    hit_idx;
		logic                old_found;
		logic [IDX_W-1:0]    old_idx;
		logic [KEY_BITS-1:0] old_key;
		logic                free_found;
		logic [IDX_W-1:0]    free_idx;
	} scan_res_t;

	// clamp the programmed limit into 1 .. ENTRIES
	function automatic logic [LIM_W-1:0] eff_limit(input logic [CAP_W-1:0] cap);
		logic [LIM_W-1:0] lim;
		lim = LIM_W'(cap);
		if (cap == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(cap) > LIM_W'(ENTRIES)) begin
			lim = LIM_W'(ENTRIES);
		end
		return lim;
	endfunction

endpackage

/* hdl/lkpc_ifs.sv */
interface lkpc_req_if import lkpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [KEY_BITS-1:0] lookup_key;

	modport source (output valid, output func, output lookup_key, input ready);
	modport sink (input valid, input func, input lookup_key, output ready);
endinterface

interface lkpc_rsp_if import lkpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   slot;
	logic [KEY_BITS-1:0] evicted_key;
	logic [OCC_W-1:0]    occupancy;
	logic [CTR_W-1:0]    build_total;
	logic [CTR_W-1:0]    eviction_total;
	logic [CTR_W-1:0]    fallback_total;

	modport source (output valid, output status, output slot, output evicted_key,
		output occupancy, output build_total, output eviction_total,
		output fallback_total, input ready);
	modport sink (input valid, input status, input slot, input evicted_key,
		input occupancy, input build_total, input eviction_total,
		input fallback_total, output ready);
endinterface

interface lkpc_cfg_if import lkpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/lru_keyed_plan_cache_unit.sv */
// channel  dir  handshake          payload
// req      in   valid / ready      func, lookup_key
// rsp      out  valid / ready      status, slot, evicted_key, occupancy, counters
// cfg      in   valid / ready      index, data (0 capacity_limit, 1 evict_enabled)
//
// A request is taken in S_IDLE, and no other until it commits; in S_SCAN the compare
// unit walks the 64 entries through the read port of the key and stamp memories, and
// S_DECIDE commits. The result sits in an output register; the next request is taken
// while it waits, but a commit holds until the previous result has been taken.
// Reset clears the valid bits at once; no clearing pass. cfg is always ready.
module lru_keyed_plan_cache_unit import lkpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lkpc_req_if.sink    req,
	lkpc_rsp_if.source  rsp,
	lkpc_cfg_if.sink    cfg
);
	state_t              state_q;
	state_t              state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic                step_s1;
	logic [IDX_W-1:0]    idx_s1;
	func_t               func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    occ_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [CTR_W-1:0]    build_q;
	logic [CTR_W-1:0]    evict_q;
	logic [CTR_W-1:0]    fallback_q;
	logic [CAP_W-1:0]    cap_q;
	logic                evict_en_q;
	logic                rsp_vld_q;
	status_t             stat_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [KEY_BITS-1:0] evk_q;

	logic                accept;
	logic                commit;
	logic                scan_end;
	logic                full;
	scan_ctl_t           scan_ctl;
	scan_res_t           scan_res;
	logic [KEY_BITS-1:0] key_rdata;
	logic [STAMP_W-1:0]  stamp_rdata;

	status_t             stat_d;
	logic [IDX_W-1:0]    slot_idx;
	logic [KEY_BITS-1:0] evk_d;
	logic [IDX_W-1:0]    w_idx;
	logic                wr_key;
	logic                wr_stamp;
	logic                bump_build;
	logic                bump_evict;
	logic                bump_fb;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign scan_end = (cnt_q == CNT_W'(ENTRIES));
	assign commit = (state_q == S_DECIDE) && (!rsp_vld_q || rsp.ready);
	assign full = LIM_W'(occ_q) >= eff_limit(cap_q);

	assign scan_ctl.clear = accept;
	assign scan_ctl.step = step_s1;
	assign scan_ctl.idx = idx_s1;
	assign scan_ctl.live = valid_q[idx_s1];

	lkpc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (commit && wr_key),
		.waddr (w_idx),
		.wdata (key_q),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (key_rdata)
	);

	lkpc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
		.clk   (clk),
		.we    (commit && wr_stamp),
		.waddr (w_idx),
		.wdata (clock_q + STAMP_W'(1)),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (stamp_rdata)
	);

	lkpc_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.probe_key   (key_q),
		.entry_key   (key_rdata),
		.entry_stamp (stamp_rdata),
		.res         (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outcome of the request once the scan has finished
	always_comb begin
		stat_d = STAT_REFUSED;
		slot_idx = '0;
		evk_d = '0;
		w_idx = scan_res.free_idx;
		wr_key = 1'b0;
		wr_stamp = 1'b0;
		bump_build = 1'b0;
		bump_evict = 1'b0;
		bump_fb = 1'b0;
		if (func_q == FN_QUERY) begin
			if (scan_res.hit) begin
				stat_d = STAT_AVAIL;
				slot_idx = scan_res.hit_idx;
			end else if (!full || evict_en_q) begin
				stat_d = STAT_AVAIL;
			end else begin
				stat_d = STAT_UNAVAIL;
				bump_fb = 1'b1;
			end
		end else if (scan_res.hit) begin
			stat_d = STAT_HIT;
			slot_idx = scan_res.hit_idx;
			w_idx = scan_res.hit_idx;
			wr_stamp = 1'b1;
		end else if (full && !evict_en_q) begin
			stat_d = STAT_REFUSED;
		end else if (full && scan_res.old_found) begin
			stat_d = STAT_EVICTED;
			evk_d = scan_res.old_key;
			slot_idx = scan_res.old_idx;
			w_idx = scan_res.old_idx;
			wr_key = 1'b1;
			wr_stamp = 1'b1;
			bump_build = 1'b1;
			bump_evict = 1'b1;
		end else if (scan_res.free_found) begin
			stat_d = STAT_INSERTED;
			slot_idx = scan_res.free_idx;
			wr_key = 1'b1;
			wr_stamp = 1'b1;
			bump_build = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			step_s1 <= 1'b0;
			valid_q <= '0;
			occ_q <= '0;
			clock_q <= '0;
			build_q <= '0;
			evict_q <= '0;
			fallback_q <= '0;
			cap_q <= CAP_RESET;
			evict_en_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			step_s1 <= (state_q == S_SCAN) && !scan_end;
			if (accept) begin
				cnt_q <= '0;
			end else if ((state_q == S_SCAN) && !scan_end) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					CFG_CAPACITY: cap_q <= cfg.data[CAP_W-1:0];
					CFG_EVICT:    evict_en_q <= cfg.data[0];
					default:      evict_en_q <= evict_en_q;
				endcase
			end
			if (commit) begin
				rsp_vld_q <= 1'b1;
				if (wr_stamp) begin
					clock_q <= clock_q + STAMP_W'(1);
				end
				if (wr_key) begin
					valid_q[w_idx] <= 1'b1;
				end
				// an eviction reuses its slot, so occupancy only grows on a plain insert
				if (bump_build && !bump_evict) begin
					occ_q <= occ_q + CNT_W'(1);
				end
				if (bump_build) begin
					build_q <= build_q + CTR_W'(1);
				end
				if (bump_evict) begin
					evict_q <= evict_q + CTR_W'(1);
				end
				if (bump_fb) begin
					fallback_q <= fallback_q + CTR_W'(1);
				end
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1 || (state_q == S_SCAN)) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (accept) begin
			func_q <= func_t'(req.func);
			key_q <= req.lookup_key;
		end
		if (commit) begin
			stat_q <= stat_d;
			slot_q <= SLOT_W'(slot_idx);
			evk_q <= evk_d;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.status = stat_q;
	assign rsp.slot = slot_q;
	assign rsp.evicted_key = evk_q;
	assign rsp.occupancy = OCC_W'(occ_q);
	assign rsp.build_total = build_q;
	assign rsp.eviction_total = evict_q;
	assign rsp.fallback_total = fallback_q;

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CNT_W'($countones(valid_q)))
		else $error("occupancy disagrees with valid map");

	a_build_moves_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(build_q != $past(build_q)) |-> (clock_q != $past(clock_q)))
		else $error("insertion without use clock advance");

	a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && scan_res.hit) |=> (occ_q == $past(occ_q)))
		else $error("occupancy changed on a hit");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (stat_d == STAT_EVICTED)) |-> valid_q[w_idx])
		else $error("eviction of an empty slot");
endmodule

/* hdl/lkpc_ram.sv */
module lkpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* hdl/lkpc_scan.sv */
module lkpc_scan import lkpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_ctl_t           ctl,
	input  logic [KEY_BITS-1:0] probe_key,
	input  logic [KEY_BITS-1:0] entry_key,
	input  logic [STAMP_W-1:0]  entry_stamp,
	output scan_res_t           res
);
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                old_found_q;
	logic [IDX_W-1:0]    old_idx_q;
	logic [KEY_BITS-1:0] old_key_q;
	logic [STAMP_W-1:0]  old_stamp_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic match;
	logic older;
	logic take_hit;
	logic take_free;

	// strict compare keeps the lowest index on a stamp tie
	assign match = ctl.live && (entry_key == probe_key);
	assign older = ctl.live && (!old_found_q || (entry_stamp < old_stamp_q));
	assign take_hit = ctl.step && match && !hit_q;
	assign take_free = ctl.step && !ctl.live && !free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			old_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
			old_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (ctl.step && older) begin
				old_found_q <= 1'b1;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= ctl.idx;
		end
		if (ctl.step && older) begin
			old_idx_q <= ctl.idx;
			old_key_q <= entry_key;
			old_stamp_q <= entry_stamp;
		end
		if (take_free) begin
			free_idx_q <= ctl.idx;
		end
	end

	always_comb begin
		res.hit = hit_q;
		res.hit_idx = hit_idx_q;
		res.old_found = old_found_q;
		res.old_idx = old_idx_q;
		res.old_key = old_key_q;
		res.free_found = free_found_q;
		res.free_idx = free_idx_q;
	end
endmodule
